// ----- hdl/cfp_pkg.sv -----
package cfp_pkg;

    localparam int unsigned PAYLOAD_LEN = 13;
    localparam logic [3:0]  POS_HUNT    = 4'd0;
    localparam logic [3:0]  POS_FIRST   = 4'd1;
    localparam logic [3:0]  CRC_POS     = 4'd14;
    localparam logic [7:0]  CRC_POLY    = 8'h07;
    localparam logic [7:0]  HEADER_RST  = 8'hA5;

    typedef struct packed {
        logic [31:0] x_bits;
        logic [31:0] y_bits;
        logic [31:0] yaw_bits;
        logic [7:0]  status_byte;
        logic        crc_error;
    } t_result;

    // Byte-wide CRC-8 update, MSB first, no reflection.
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] v;
        v = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (v[7]) begin
                v = {v[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                v = {v[6:0], 1'b0};
            end
        end
        return v;
    endfunction

endpackage

// ----- hdl/crc8_frame_parser_top.sv -----
// Byte-serial frame deframer. It hunts for the header byte (i_cfg_data written with
// i_cfg_we, 0xA5 after reset), then collects 13 payload bytes and a CRC-8 byte
// (polynomial 0x07, initial value 0, MSB first) and gives one result per frame: three
// little-endian 32-bit words, the status byte and a CRC error flag; on an error the
// data fields are zero. One byte is taken in every cycle; the CRC and the frame
// position are updated in that same cycle, and the result is loaded into the output
// register when the CRC byte is taken. The input only stalls when a CRC byte arrives
// while the previous result still sits unaccepted in the output register.
module crc8_frame_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_rx_valid,
    output logic        o_rx_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output logic [31:0] o_x_bits,
    output logic [31:0] o_y_bits,
    output logic [31:0] o_yaw_bits,
    output logic [7:0]  o_status_byte,
    output logic        o_crc_error
);

    logic [7:0]       r_header;
    logic [3:0]       r_pos;
    logic [3:0]       n_pos;
    logic [7:0]       r_crc;
    logic [7:0]       n_crc;
    logic [7:0]       r_payload [cfp_pkg::PAYLOAD_LEN];
    logic             accept;
    logic             at_crc;
    logic             crc_bad;
    logic             can_load;
    logic             load;
    cfp_pkg::t_result result;
    cfp_pkg::t_result out_result;

    assign at_crc     = (r_pos >= cfp_pkg::CRC_POS);
    assign o_rx_ready = !at_crc || can_load;
    assign accept     = i_rx_valid && o_rx_ready;
    assign crc_bad    = (i_rx_byte != r_crc);
    assign load       = accept && at_crc;

    always_comb begin
        n_pos = r_pos;
        n_crc = r_crc;
        if (accept) begin
            if (r_pos == cfp_pkg::POS_HUNT) begin
                if (i_rx_byte == r_header) begin
                    n_pos = cfp_pkg::POS_FIRST;
                    n_crc = 8'h00;
                end
            end else if (!at_crc) begin
                n_pos = r_pos + 4'd1;
                n_crc = cfp_pkg::crc8_update(r_crc, i_rx_byte);
            end else begin
                // A failed frame whose CRC byte looks like a header starts a new frame.
                n_crc = 8'h00;
                n_pos = (crc_bad && (i_rx_byte == r_header)) ? cfp_pkg::POS_FIRST
                                                             : cfp_pkg::POS_HUNT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header <= cfp_pkg::HEADER_RST;
            r_pos    <= cfp_pkg::POS_HUNT;
            r_crc    <= 8'h00;
        end else begin
            if (i_cfg_we) begin
                r_header <= i_cfg_data;
            end
            r_pos <= n_pos;
            r_crc <= n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < int'(cfp_pkg::PAYLOAD_LEN); i++) begin
            if (accept && (r_pos == 4'(i + 1))) begin
                r_payload[i] <= i_rx_byte;
            end
        end
    end

    always_comb begin
        if (crc_bad) begin
            result = '0;
            result.crc_error = 1'b1;
        end else begin
            result.x_bits      = {r_payload[3], r_payload[2], r_payload[1], r_payload[0]};
            result.y_bits      = {r_payload[7], r_payload[6], r_payload[5], r_payload[4]};
            result.yaw_bits    = {r_payload[11], r_payload[10], r_payload[9], r_payload[8]};
            result.status_byte = r_payload[12];
            result.crc_error   = 1'b0;
        end
    end

    cfp_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .i_result   (result),
        .o_can_load (can_load),
        .o_valid    (o_res_valid),
        .i_ready    (i_res_ready),
        .o_result   (out_result)
    );

    assign o_x_bits      = out_result.x_bits;
    assign o_y_bits      = out_result.y_bits;
    assign o_yaw_bits    = out_result.yaw_bits;
    assign o_status_byte = out_result.status_byte;
    assign o_crc_error   = out_result.crc_error;

endmodule

// ----- hdl/cfp_out_reg.sv -----
module cfp_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  cfp_pkg::t_result i_result,
    output logic             o_can_load,
    output logic             o_valid,
    input  logic             i_ready,
    output cfp_pkg::t_result o_result
);

    logic             r_valid;
    logic             n_valid;
    cfp_pkg::t_result r_result;

    assign o_can_load = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ----- hdl/cfp_checker.sv -----
module cfp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_rx_valid,
    input logic        o_rx_ready,
    input logic        o_res_valid,
    input logic        i_res_ready,
    input logic [31:0] o_x_bits,
    input logic [31:0] o_y_bits,
    input logic [31:0] o_yaw_bits,
    input logic [7:0]  o_status_byte,
    input logic        o_crc_error
);

    // A stalled result transaction keeps its data.
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_ready |=> o_res_valid && $stable(o_x_bits)
            && $stable(o_y_bits) && $stable(o_yaw_bits) && $stable(o_status_byte)
            && $stable(o_crc_error))
        else $error("result changed while stalled");

    // A failed frame carries zero data fields.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_crc_error |-> (o_x_bits == 32'd0) && (o_y_bits == 32'd0)
            && (o_yaw_bits == 32'd0) && (o_status_byte == 8'd0))
        else $error("error result with nonzero fields");

    // The input only stalls behind a full, stalled output register.
    a_rx_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_rx_ready |-> o_res_valid && !i_res_ready)
        else $error("input stalled without output backpressure");

    // A new result appears only after an input transaction.
    a_res_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res_valid) |-> $past(i_rx_valid && o_rx_ready))
        else $error("result without an input transaction");

endmodule

bind crc8_frame_parser_top cfp_checker u_cfp_checker (.*);
